// ===== design/bpl_pkg.sv =====
package bpl_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] element_index;
    logic [5:0] priority_req;
  } bpl_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       empty_res;
    logic [5:0] max_level;
    logic [9:0] top_element;
  } bpl_out_t;

  localparam logic [1:0] KIND_INSERT    = 2'd0;
  localparam logic [1:0] KIND_MOVE_HEAD = 2'd1;
  localparam logic [1:0] KIND_MOVE_TAIL = 2'd2;
  localparam logic [1:0] KIND_ERASE     = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_CHK,
    S_UNLINK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_LINK_RD,
    S_LINK_WR1,
    S_LINK_WR2,
    S_TOP_RD,
    S_TOP_CHK
  } bpl_state_t;

endpackage

// ===== design/bucket_priority_list_unit.sv =====
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall   | bpl_pkg::bpl_in_t
// out_    | output    | out_valid / out_stall | bpl_pkg::bpl_out_t
//
// an item is handled one at a time; while the new top level is searched,
// each empty level skipped takes a read on the single head memory port
// after reset a clearing pass writes every presence, head and tail entry,
// during which in_stall is high
// a result waits in the output register while out_stall is high; the next
// item is taken meanwhile, but its result waits until the register is free
module bucket_priority_list_unit #(
  parameter int NUM_ELEMENTS = 1024,
  parameter int NUM_LEVELS   = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpl_pkg::bpl_in_t    in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bpl_pkg::bpl_out_t   out_item
);

  localparam int IW    = $clog2(NUM_ELEMENTS);
  localparam int VW    = $clog2(NUM_LEVELS);
  localparam int LW    = $clog2(NUM_ELEMENTS + 1);
  localparam int CLR_N = (NUM_ELEMENTS > NUM_LEVELS) ? NUM_ELEMENTS : NUM_LEVELS;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [LW-1:0] NONE = LW'(NUM_ELEMENTS);

  bpl_pkg::bpl_state_t state_r, state_nxt;
  logic [CW-1:0]       clr_r, clr_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [9:0]          e_r, e_nxt;
  logic [VW-1:0]       lv_r, lv_nxt;
  logic [1:0]          status_r, status_nxt;
  logic signed [VW:0]  top_r, top_nxt;
  logic                out_valid_r, out_valid_nxt;
  bpl_pkg::bpl_out_t   out_r, out_nxt;

  logic          pres_we, pres_wd, pres_re, pres_rd;
  logic [IW-1:0] pres_wa, el_ra;
  logic          lvl_we, lvl_re;
  logic [IW-1:0] lvl_wa;
  logic [VW-1:0] lvl_wd, lvl_rd;
  logic          prev_we, prev_re, next_we, next_re;
  logic [IW-1:0] prev_wa, next_wa;
  logic [LW-1:0] prev_wd, prev_rd, next_wd, next_rd;
  logic          head_we, head_re, tail_we, tail_re;
  logic [VW-1:0] head_wa, head_ra, tail_wa, tail_ra;
  logic [LW-1:0] head_wd, head_rd, tail_wd, tail_rd;

  logic               accept, load_out, in_range, present, is_tail_kind;
  logic               p_ok, n_ok, h_ok, t_ok, hrd_ok;
  logic [IW-1:0]      e_idx;
  logic [LW-1:0]      e_lnk;
  logic [VW-1:0]      in_lv;
  logic signed [VW:0] tgt, lv_s;
  logic [31:0]        top32, head32;

  assign accept       = in_valid && !in_stall;
  assign in_stall     = (state_r != bpl_pkg::S_IDLE);
  assign e_idx        = IW'(e_r);
  assign e_lnk        = LW'(e_r);
  assign in_range     = (32'(e_r) < NUM_ELEMENTS);
  assign present      = in_range && pres_rd;
  assign is_tail_kind = (kind_r == bpl_pkg::KIND_INSERT) ||
                        (kind_r == bpl_pkg::KIND_MOVE_TAIL);
  assign p_ok         = (32'(prev_rd) < NUM_ELEMENTS);
  assign n_ok         = (32'(next_rd) < NUM_ELEMENTS);
  assign h_ok         = (32'(head_rd) < NUM_ELEMENTS);
  assign t_ok         = (32'(tail_rd) < NUM_ELEMENTS);
  assign hrd_ok       = h_ok;
  assign in_lv        = (32'(in_item.priority_req) >= NUM_LEVELS) ? VW'(NUM_LEVELS - 1)
                                                                  : VW'(in_item.priority_req);
  assign lv_s         = $signed({1'b0, lv_r});
  assign tgt          = (kind_r == bpl_pkg::KIND_ERASE) ? '1 : lv_s;
  assign top32        = 32'(top_r[VW-1:0]);
  assign head32       = 32'(head_rd);
  assign load_out     = (state_r == bpl_pkg::S_TOP_CHK) && (!out_valid_r || !out_stall);

  bpl_ram #(.DEPTH(NUM_ELEMENTS), .WIDTH(1)) u_pres (
    .clk, .we(pres_we), .waddr(pres_wa), .wdata(pres_wd),
    .re(pres_re), .raddr(el_ra), .rdata(pres_rd)
  );
  bpl_ram #(.DEPTH(NUM_ELEMENTS), .WIDTH(VW)) u_lvl (
    .clk, .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd),
    .re(lvl_re), .raddr(el_ra), .rdata(lvl_rd)
  );
  bpl_ram #(.DEPTH(NUM_ELEMENTS), .WIDTH(LW)) u_prev (
    .clk, .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .re(prev_re), .raddr(el_ra), .rdata(prev_rd)
  );
  bpl_ram #(.DEPTH(NUM_ELEMENTS), .WIDTH(LW)) u_next (
    .clk, .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .re(next_re), .raddr(el_ra), .rdata(next_rd)
  );
  bpl_ram #(.DEPTH(NUM_LEVELS), .WIDTH(LW)) u_head (
    .clk, .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .re(head_re), .raddr(head_ra), .rdata(head_rd)
  );
  bpl_ram #(.DEPTH(NUM_LEVELS), .WIDTH(LW)) u_tail (
    .clk, .we(tail_we), .waddr(tail_wa), .wdata(tail_wd),
    .re(tail_re), .raddr(tail_ra), .rdata(tail_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpl_pkg::S_CLR;
      clr_r       <= '0;
      top_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    e_r      <= e_nxt;
    lv_r     <= lv_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpl_pkg::S_CLR: begin
        if (clr_r == CW'(CLR_N - 1)) state_nxt = bpl_pkg::S_IDLE;
      end
      bpl_pkg::S_IDLE: begin
        if (accept) state_nxt = bpl_pkg::S_CHK;
      end
      bpl_pkg::S_CHK: begin
        if (kind_r == bpl_pkg::KIND_INSERT) begin
          state_nxt = (!in_range || present) ? bpl_pkg::S_TOP_RD : bpl_pkg::S_LINK_RD;
        end else begin
          state_nxt = present ? bpl_pkg::S_UNLINK : bpl_pkg::S_TOP_RD;
        end
      end
      bpl_pkg::S_UNLINK: state_nxt = bpl_pkg::S_SCAN_RD;
      bpl_pkg::S_SCAN_RD: begin
        if (top_r > tgt && !top_r[VW]) begin
          state_nxt = bpl_pkg::S_SCAN_CHK;
        end else begin
          state_nxt = (kind_r == bpl_pkg::KIND_ERASE) ? bpl_pkg::S_TOP_RD
                                                      : bpl_pkg::S_LINK_RD;
        end
      end
      bpl_pkg::S_SCAN_CHK: begin
        if (!hrd_ok) begin
          state_nxt = bpl_pkg::S_SCAN_RD;
        end else begin
          state_nxt = (kind_r == bpl_pkg::KIND_ERASE) ? bpl_pkg::S_TOP_RD
                                                      : bpl_pkg::S_LINK_RD;
        end
      end
      bpl_pkg::S_LINK_RD:  state_nxt = bpl_pkg::S_LINK_WR1;
      bpl_pkg::S_LINK_WR1: state_nxt = bpl_pkg::S_LINK_WR2;
      bpl_pkg::S_LINK_WR2: state_nxt = bpl_pkg::S_TOP_RD;
      bpl_pkg::S_TOP_RD:   state_nxt = bpl_pkg::S_TOP_CHK;
      bpl_pkg::S_TOP_CHK: begin
        if (load_out) state_nxt = bpl_pkg::S_IDLE;
      end
      default: state_nxt = bpl_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    clr_nxt       = clr_r;
    kind_nxt      = kind_r;
    e_nxt         = e_r;
    lv_nxt        = lv_r;
    status_nxt    = status_r;
    top_nxt       = top_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    el_ra   = IW'(in_item.element_index);
    pres_re = 1'b0; lvl_re = 1'b0; prev_re = 1'b0; next_re = 1'b0;
    pres_we = 1'b0; pres_wa = e_idx; pres_wd = 1'b0;
    lvl_we  = 1'b0; lvl_wa  = e_idx; lvl_wd  = lv_r;
    prev_we = 1'b0; prev_wa = e_idx; prev_wd = NONE;
    next_we = 1'b0; next_wa = e_idx; next_wd = NONE;
    head_we = 1'b0; head_wa = lv_r;  head_wd = NONE;
    tail_we = 1'b0; tail_wa = lv_r;  tail_wd = NONE;
    head_re = 1'b0; head_ra = lv_r;
    tail_re = 1'b0; tail_ra = lv_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      bpl_pkg::S_CLR: begin
        clr_nxt = clr_r + CW'(1);
        pres_we = 1'b1;
        pres_wa = clr_r[IW-1:0];
        if (32'(clr_r) < NUM_LEVELS) begin
          head_we = 1'b1; head_wa = clr_r[VW-1:0];
          tail_we = 1'b1; tail_wa = clr_r[VW-1:0];
        end
      end
      bpl_pkg::S_IDLE: begin
        pres_re = 1'b1; lvl_re = 1'b1; prev_re = 1'b1; next_re = 1'b1;
        if (accept) begin
          kind_nxt   = in_item.kind;
          e_nxt      = in_item.element_index;
          lv_nxt     = in_lv;
          status_nxt = bpl_pkg::ST_DONE;
        end
      end
      bpl_pkg::S_CHK: begin
        if (kind_r == bpl_pkg::KIND_INSERT) begin
          if (!in_range) status_nxt = bpl_pkg::ST_ABSENT;
          else if (present) status_nxt = bpl_pkg::ST_PRESENT;
        end else if (!present) begin
          status_nxt = bpl_pkg::ST_ABSENT;
        end
      end
      bpl_pkg::S_UNLINK: begin
        if (p_ok) begin
          next_we = 1'b1; next_wa = prev_rd[IW-1:0]; next_wd = next_rd;
        end else begin
          head_we = 1'b1; head_wa = lvl_rd; head_wd = next_rd;
        end
        if (n_ok) begin
          prev_we = 1'b1; prev_wa = next_rd[IW-1:0]; prev_wd = prev_rd;
        end else begin
          tail_we = 1'b1; tail_wa = lvl_rd; tail_wd = prev_rd;
        end
        if (kind_r == bpl_pkg::KIND_ERASE) pres_we = 1'b1;
        if (tgt > top_r) top_nxt = tgt;
      end
      bpl_pkg::S_SCAN_RD: begin
        head_re = top_r > tgt && !top_r[VW];
        head_ra = top_r[VW-1:0];
      end
      bpl_pkg::S_SCAN_CHK: begin
        if (!hrd_ok) top_nxt = top_r - (VW+1)'(1);
      end
      bpl_pkg::S_LINK_RD: begin
        head_re = 1'b1;
        tail_re = 1'b1;
      end
      bpl_pkg::S_LINK_WR1: begin
        lvl_we = 1'b1;
        if (is_tail_kind) begin
          prev_we = 1'b1; prev_wd = tail_rd;
          next_we = 1'b1;
          tail_we = 1'b1; tail_wd = e_lnk;
          if (!t_ok) begin
            head_we = 1'b1; head_wd = e_lnk;
          end
        end else begin
          next_we = 1'b1; next_wd = head_rd;
          prev_we = 1'b1;
          head_we = 1'b1; head_wd = e_lnk;
          if (!h_ok) begin
            tail_we = 1'b1; tail_wd = e_lnk;
          end
        end
        if (kind_r == bpl_pkg::KIND_INSERT) begin
          pres_we = 1'b1;
          pres_wd = 1'b1;
          if (lv_s > top_r) top_nxt = lv_s;
        end
      end
      bpl_pkg::S_LINK_WR2: begin
        if (is_tail_kind) begin
          if (t_ok) begin
            next_we = 1'b1; next_wa = tail_rd[IW-1:0]; next_wd = e_lnk;
          end
        end else if (h_ok) begin
          prev_we = 1'b1; prev_wa = head_rd[IW-1:0]; prev_wd = e_lnk;
        end
      end
      bpl_pkg::S_TOP_RD: begin
        head_re = !top_r[VW];
        head_ra = top_r[VW-1:0];
      end
      bpl_pkg::S_TOP_CHK: begin
        if (load_out) begin
          out_valid_nxt    = 1'b1;
          out_nxt.status   = status_r;
          out_nxt.empty_res = top_r[VW];
          if (top_r[VW]) begin
            out_nxt.max_level   = '0;
            out_nxt.top_element = '0;
          end else begin
            out_nxt.max_level   = top32[5:0];
            out_nxt.top_element = h_ok ? head32[9:0] : 10'd0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_clr_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpl_pkg::S_CLR |-> in_stall)
    else $error("item taken during clearing pass");

  a_accept_chk: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == bpl_pkg::S_CHK)
    else $error("accepted item not checked next");

  a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.empty_res |-> out_r.max_level == 6'd0 && out_r.top_element == 10'd0)
    else $error("empty result carries a level or element");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && state_r == bpl_pkg::S_IDLE)
    else $error("result load lost");

endmodule

// ===== design/bpl_ram.sv =====
module bpl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_EL  = 1024;
  localparam int NUM_LV  = 64;
  localparam int NO_LINK = NUM_EL;
  localparam int WATCHDOG_LIMIT = 20000;

  class bucket_list_scoreboard;
    int link_prev[NUM_EL];
    int link_next[NUM_EL];
    int elem_level[NUM_EL];
    bit elem_held[NUM_EL];
    int lv_head[NUM_LV];
    int lv_tail[NUM_LV];
    int top_lv;
    bpl_pkg::bpl_out_t pending_q[$];
    int mismatches;
    int held_count;

    function new();
      for (int i = 0; i < NUM_EL; i++) begin
        link_prev[i] = 0;
        link_next[i] = 0;
        elem_level[i] = 0;
        elem_held[i] = 0;
      end
      for (int i = 0; i < NUM_LV; i++) begin
        lv_head[i] = NO_LINK;
        lv_tail[i] = NO_LINK;
      end
      top_lv = -1;
      mismatches = 0;
      held_count = 0;
    endfunction

    function void detach(int e, int target);
      int lv;
      int p;
      int n;
      lv = elem_level[e];
      p = link_prev[e];
      n = link_next[e];
      if (p < NUM_EL) link_next[p] = n;
      else lv_head[lv] = n;
      if (n < NUM_EL) link_prev[n] = p;
      else lv_tail[lv] = p;
      link_prev[e] = NO_LINK;
      link_next[e] = NO_LINK;
      if (target > top_lv) begin
        top_lv = target;
      end else begin
        while (top_lv > target && top_lv >= 0 && lv_head[top_lv] >= NUM_EL) top_lv--;
      end
    endfunction

    function void attach(int e, int lv, bit at_head);
      int h;
      int t;
      if (at_head) begin
        h = lv_head[lv];
        link_next[e] = h;
        link_prev[e] = NO_LINK;
        if (h < NUM_EL) link_prev[h] = e;
        else lv_tail[lv] = e;
        lv_head[lv] = e;
      end else begin
        t = lv_tail[lv];
        link_prev[e] = t;
        link_next[e] = NO_LINK;
        if (t < NUM_EL) link_next[t] = e;
        else lv_head[lv] = e;
        lv_tail[lv] = e;
      end
      elem_level[e] = lv;
    endfunction

    function void note_item(bpl_pkg::bpl_in_t it);
      bpl_pkg::bpl_out_t r;
      int e;
      int lv;
      e = it.element_index;
      lv = it.priority_req;
      r = '0;
      r.status = bpl_pkg::ST_DONE;
      if (it.kind == bpl_pkg::KIND_INSERT) begin
        if (elem_held[e]) begin
          r.status = bpl_pkg::ST_PRESENT;
        end else begin
          attach(e, lv, 1'b0);
          elem_held[e] = 1;
          held_count++;
          if (lv > top_lv) top_lv = lv;
        end
      end else if (!elem_held[e]) begin
        r.status = bpl_pkg::ST_ABSENT;
      end else if (it.kind == bpl_pkg::KIND_ERASE) begin
        detach(e, -1);
        elem_held[e] = 0;
        held_count--;
      end else begin
        detach(e, lv);
        attach(e, lv, it.kind == bpl_pkg::KIND_MOVE_HEAD);
      end
      if (top_lv < 0) begin
        r.empty_res = 1'b1;
      end else begin
        r.max_level = top_lv[5:0];
        if (lv_head[top_lv] < NUM_EL) r.top_element = lv_head[top_lv][9:0];
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(bpl_pkg::bpl_out_t got);
      bpl_pkg::bpl_out_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status || got.empty_res !== want.empty_res ||
          got.max_level !== want.max_level || got.top_element !== want.top_element) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  bpl_pkg::bpl_in_t in_item;
  logic out_valid;
  logic out_stall;
  bpl_pkg::bpl_out_t out_item;

  bucket_list_scoreboard board;
  int idle_cycles;
  int out_wait;
  bit quiet_phase;

  bucket_priority_list_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic send_item(logic [1:0] k, int e, int lv);
    int gap;
    bpl_pkg::bpl_in_t it;
    gap = quiet_phase ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.kind = k;
    it.element_index = e[9:0];
    it.priority_req = lv[5:0];
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_held();
    int e;
    for (int tries = 0; tries < 64; tries++) begin
      e = $urandom_range(0, 63);
      if (board.elem_held[e]) return e;
    end
    return $urandom_range(0, NUM_EL - 1);
  endfunction

  // wait drawn once per result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait <= 0;
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_stall <= (out_wait > 1);
    end else if (out_valid && !out_stall) begin
      if (quiet_phase) begin
        out_wait <= 0;
        out_stall <= 1'b0;
      end else begin
        out_wait <= $urandom_range(0, 16);
        out_stall <= 1'b1;
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int e;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    idle_cycles = 0;
    quiet_phase = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, extremes, presence errors, moves, top emptying
    send_item(bpl_pkg::KIND_ERASE, 5, 0);
    send_item(bpl_pkg::KIND_MOVE_HEAD, 1023, 63);
    send_item(bpl_pkg::KIND_INSERT, 0, 0);
    send_item(bpl_pkg::KIND_INSERT, 1023, 63);
    send_item(bpl_pkg::KIND_INSERT, 1023, 10);
    send_item(bpl_pkg::KIND_INSERT, 7, 63);
    send_item(bpl_pkg::KIND_INSERT, 8, 63);
    send_item(bpl_pkg::KIND_MOVE_HEAD, 8, 63);
    send_item(bpl_pkg::KIND_MOVE_TAIL, 8, 63);
    send_item(bpl_pkg::KIND_MOVE_TAIL, 1023, 5);
    send_item(bpl_pkg::KIND_MOVE_HEAD, 7, 2);
    send_item(bpl_pkg::KIND_ERASE, 8, 0);
    send_item(bpl_pkg::KIND_MOVE_HEAD, 0, 40);
    send_item(bpl_pkg::KIND_INSERT, 682, 21);
    send_item(bpl_pkg::KIND_INSERT, 341, 42);
    send_item(bpl_pkg::KIND_ERASE, 0, 63);
    send_item(bpl_pkg::KIND_ERASE, 341, 0);
    send_item(bpl_pkg::KIND_ERASE, 682, 0);
    send_item(bpl_pkg::KIND_ERASE, 7, 0);
    send_item(bpl_pkg::KIND_ERASE, 1023, 0);
    send_item(bpl_pkg::KIND_ERASE, 1023, 0);

    quiet_phase = 1;
    wait_drained();
    quiet_phase = 0;

    for (int n = 0; n < 550; n++) begin
      r = $urandom_range(0, 99);
      if (n == 275) begin
        wait_drained();
      end
      if (r < 40) begin
        if (board.held_count < 48 || $urandom_range(0, 7) == 0)
          send_item(bpl_pkg::KIND_INSERT, $urandom_range(0, 63), $urandom_range(0, 63));
        else
          send_item(bpl_pkg::KIND_ERASE, pick_held(), $urandom_range(0, 63));
      end else if (r < 60) begin
        send_item(bpl_pkg::KIND_MOVE_HEAD, pick_held(), $urandom_range(0, 63));
      end else if (r < 78) begin
        send_item(bpl_pkg::KIND_MOVE_TAIL, pick_held(), $urandom_range(0, 63));
      end else if (r < 92) begin
        send_item(bpl_pkg::KIND_ERASE, pick_held(), $urandom_range(0, 63));
      end else begin
        e = $urandom_range(0, NUM_EL - 1);
        send_item(2'($urandom_range(0, 3)), e, $urandom_range(0, 63));
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bpl_pkg.sv
design/bpl_ram.sv
design/bucket_priority_list_unit.sv
tb/testbench.sv
